// ----- sv/fixed_point_vector_alu_defines.svh -----
// Assertion macros for the fixed point vector ALU.
// Used by the top level; no other dependencies.
`ifndef FIXED_POINT_VECTOR_ALU_DEFINES_SVH
`define FIXED_POINT_VECTOR_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/fpva_pkg.sv -----
// Shared constants and types for the fixed point vector ALU.
// No dependencies.
`timescale 1ns / 1ps
package fpva_pkg;
    localparam int FPVA_WORD_BITS = 32;
    localparam int FPVA_FRAC_BITS = 16;
    localparam int FPVA_LANES     = 4;
    localparam logic [2:0] CNT_RESET = 3'd4;
    localparam logic [2:0] CNT_MIN   = 3'd2;
    localparam logic [2:0] CNT_MAX   = 3'd4;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_ADDS  = 4'd3,
        OP_MULS  = 4'd4,
        OP_DIVS  = 4'd5,
        OP_DOT   = 4'd6,
        OP_LENSQ = 4'd7,
        OP_CROSS = 4'd8,
        OP_QUAT  = 4'd9,
        OP_UNIT  = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZLEN = 2'd1,
        ST_DIVZ = 2'd2,
        ST_SAT  = 2'd3
    } t_status;
endpackage

// ----- sv/fpva_lane.sv -----
// One component lane: operand select, add/subtract path, four multipliers, signed product sum.
// Depends on fpva_pkg.
`timescale 1ns / 1ps
module fpva_lane import fpva_pkg::*; #(
    parameter int WORD_BITS = FPVA_WORD_BITS,
    parameter int LANE      = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  t_op                                    i_op,
    input  logic [2:0]                             i_n,
    input  logic [FPVA_LANES-1:0][WORD_BITS-1:0]   i_a,
    input  logic [FPVA_LANES-1:0][WORD_BITS-1:0]   i_b,
    input  logic [WORD_BITS-1:0]                   i_s,
    output logic [2*WORD_BITS+1:0]                 o_sum,
    output logic [WORD_BITS:0]                     o_e
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2*W + 2;
    localparam int J  = (LANE + 1) % 3;
    localparam int K  = (LANE + 2) % 3;

    logic signed [W-1:0]   x [4];
    logic signed [W-1:0]   y [4];
    logic [3:0]            ng;
    logic [W:0]            n_e;
    logic [PW-1:0]         n_sum;
    logic signed [2*W-1:0] r_p [4];
    logic [3:0]            r_ng;
    logic [W:0]            r_e;
    logic [W:0]            r_e2;
    logic [PW-1:0]         r_sum;
    logic                  used;

    assign used = (3'(LANE) < i_n);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            x[k] = '0;
            y[k] = '0;
        end
        ng  = '0;
        n_e = '0;
        case (i_op)
            OP_ADD:  n_e = {i_a[LANE][W-1], i_a[LANE]} + {i_b[LANE][W-1], i_b[LANE]};
            OP_SUB:  n_e = {i_a[LANE][W-1], i_a[LANE]} - {i_b[LANE][W-1], i_b[LANE]};
            OP_ADDS: n_e = {i_a[LANE][W-1], i_a[LANE]} + {i_s[W-1], i_s};
            OP_MUL: begin
                x[0] = i_a[LANE];
                y[0] = i_b[LANE];
            end
            OP_MULS: begin
                x[0] = i_a[LANE];
                y[0] = i_s;
            end
            OP_DOT: begin
                if (used) begin
                    x[0] = i_a[LANE];
                    y[0] = i_b[LANE];
                end
            end
            OP_LENSQ, OP_UNIT: begin
                if (used) begin
                    x[0] = i_a[LANE];
                    y[0] = i_a[LANE];
                end
            end
            OP_CROSS: begin
                if (LANE < 3) begin
                    x[2] = i_a[J];
                    y[2] = i_b[K];
                    x[3] = i_a[K];
                    y[3] = i_b[J];
                    ng[3] = 1'b1;
                end
            end
            OP_QUAT: begin
                if (LANE < 3) begin
                    x[0] = i_a[3];
                    y[0] = i_b[LANE];
                    x[1] = i_b[3];
                    y[1] = i_a[LANE];
                    x[2] = i_a[J];
                    y[2] = i_b[K];
                    x[3] = i_a[K];
                    y[3] = i_b[J];
                    ng[3] = 1'b1;
                end else begin
                    x[0] = i_a[3];
                    y[0] = i_b[3];
                    x[1] = i_a[0];
                    y[1] = i_b[0];
                    x[2] = i_a[1];
                    y[2] = i_b[1];
                    x[3] = i_a[2];
                    y[3] = i_b[2];
                    ng[3:1] = 3'b111;
                end
            end
            default: n_e = '0;
        endcase
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 4; k++) begin
            if (r_ng[k]) begin
                n_sum = n_sum - {{2{r_p[k][2*W-1]}}, r_p[k]};
            end else begin
                n_sum = n_sum + {{2{r_p[k][2*W-1]}}, r_p[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= x[k] * y[k];
            end
            r_ng  <= ng;
            r_e   <= n_e;
            r_sum <= n_sum;
            r_e2  <= r_e;
        end
    end

    assign o_sum = r_sum;
    assign o_e   = r_e2;
endmodule

// ----- sv/fpva_merge.sv -----
// Merge stage: scales and saturates lane results, sums lanes for dot and length.
// Depends on fpva_pkg.
`timescale 1ns / 1ps
module fpva_merge import fpva_pkg::*; #(
    parameter int WORD_BITS = FPVA_WORD_BITS,
    parameter int FRAC_BITS = FPVA_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  t_op                                    i_op,
    input  logic [2:0]                             i_n,
    input  logic [FPVA_LANES-1:0][WORD_BITS-1:0]   i_a,
    input  logic [FPVA_LANES-1:0][2*WORD_BITS+1:0] i_sum,
    input  logic [FPVA_LANES-1:0][WORD_BITS:0]     i_e,
    output logic [FPVA_LANES-1:0][WORD_BITS-1:0]   o_v,
    output logic                                   o_vovf,
    output logic [WORD_BITS-1:0]                   o_scal,
    output logic                                   o_sovf,
    output logic [2*WORD_BITS:0]                   o_acc
);
    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2*W + 2;
    localparam int AW = 2*W + 4;

    function automatic logic [W:0] sat_prod(input logic [PW-1:0] v);
        logic [PW-1:0] t;
        logic          ok;
        t  = $signed(v) >>> F;
        ok = (&t[PW-1:W-1]) | ~(|t[PW-1:W-1]);
        return ok ? {1'b0, t[W-1:0]} : {1'b1, t[PW-1], {(W-1){~t[PW-1]}}};
    endfunction

    function automatic logic [W:0] sat_acc(input logic [AW-1:0] v);
        logic [AW-1:0] t;
        logic          ok;
        t  = $signed(v) >>> F;
        ok = (&t[AW-1:W-1]) | ~(|t[AW-1:W-1]);
        return ok ? {1'b0, t[W-1:0]} : {1'b1, t[AW-1], {(W-1){~t[AW-1]}}};
    endfunction

    function automatic logic [W:0] sat_e(input logic [W:0] v);
        return (v[W] == v[W-1]) ? {1'b0, v[W-1:0]} : {1'b1, v[W], {(W-1){~v[W]}}};
    endfunction

    logic [AW-1:0]                   acc;
    logic [FPVA_LANES-1:0][W-1:0]    n_v;
    logic                            n_vovf;
    logic [W:0]                      n_sc;
    logic [W:0]                      t;
    logic                            used;
    logic [FPVA_LANES-1:0][W-1:0]    r_v;
    logic                            r_vovf;
    logic [W-1:0]                    r_scal;
    logic                            r_sovf;
    logic [2*W:0]                    r_acc;

    always_comb begin
        acc = '0;
        for (int i = 0; i < FPVA_LANES; i++) begin
            acc = acc + {{2{i_sum[i][PW-1]}}, i_sum[i]};
        end
        n_v    = i_a;
        n_vovf = 1'b0;
        t      = '0;
        used   = 1'b0;
        for (int i = 0; i < FPVA_LANES; i++) begin
            used = (3'(i) < i_n);
            case (i_op)
                OP_ADD, OP_SUB, OP_ADDS: begin
                    t = sat_e(i_e[i]);
                    if (used) begin
                        n_v[i] = t[W-1:0];
                        n_vovf = n_vovf | t[W];
                    end
                end
                OP_MUL, OP_MULS: begin
                    t = sat_prod(i_sum[i]);
                    if (used) begin
                        n_v[i] = t[W-1:0];
                        n_vovf = n_vovf | t[W];
                    end
                end
                OP_CROSS: begin
                    t = sat_prod(i_sum[i]);
                    if (i < 3) begin
                        n_v[i] = t[W-1:0];
                        n_vovf = n_vovf | t[W];
                    end
                end
                OP_QUAT: begin
                    t = sat_prod(i_sum[i]);
                    n_v[i] = t[W-1:0];
                    n_vovf = n_vovf | t[W];
                end
                default: t = '0;
            endcase
        end
        if (i_op == OP_DOT || i_op == OP_LENSQ) begin
            n_sc = sat_acc(acc);
        end else begin
            n_sc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_vovf <= n_vovf;
            r_scal <= n_sc[W-1:0];
            r_sovf <= n_sc[W];
            r_acc  <= acc[2*W:0];
        end
    end

    assign o_v    = r_v;
    assign o_vovf = r_vovf;
    assign o_scal = r_scal;
    assign o_sovf = r_sovf;
    assign o_acc  = r_acc;
endmodule

// ----- sv/fpva_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on fpva_pkg.
`timescale 1ns / 1ps
module fpva_sqrt import fpva_pkg::*; #(
    parameter int WORD_BITS = FPVA_WORD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2*WORD_BITS+1:0] i_sum,
    output logic [WORD_BITS:0]     o_root
);
    localparam int W  = WORD_BITS;
    localparam int SQ = W + 1;
    localparam int SW = 2*W + 2;
    localparam int RW = W + 4;
    localparam int QW = W + 1;

    logic [RW-1:0] r_rem  [SQ];
    logic [RW-1:0] p_rem  [SQ];
    logic [RW-1:0] n_rem  [SQ];
    logic [QW-1:0] r_root [SQ];
    logic [QW-1:0] p_root [SQ];
    logic [QW-1:0] n_root [SQ];
    logic [SW-1:0] r_s    [SQ];
    logic [SW-1:0] p_s    [SQ];
    logic [SW-1:0] n_s    [SQ];

    for (genvar k = 0; k < SQ; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign p_rem[k]  = '0;
            assign p_root[k] = '0;
            assign p_s[k]    = i_sum;
        end else begin : g_next
            assign p_rem[k]  = r_rem[k-1];
            assign p_root[k] = r_root[k-1];
            assign p_s[k]    = r_s[k-1];
        end

        always_comb begin
            logic [RW-1:0] rem2;
            logic [RW-1:0] trial;
            rem2  = {p_rem[k][RW-3:0], p_s[k][SW-1:SW-2]};
            trial = RW'({p_root[k], 2'b01});
            if (rem2 >= trial) begin
                n_rem[k]  = rem2 - trial;
                n_root[k] = {p_root[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem2;
                n_root[k] = {p_root[k][QW-2:0], 1'b0};
            end
            n_s[k] = {p_s[k][SW-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_s[k]    <= n_s[k];
            end
        end
    end

    assign o_root = r_root[SQ-1];
endmodule

// ----- sv/fpva_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, fraction-scaled numerator.
// Depends on fpva_pkg.
`timescale 1ns / 1ps
module fpva_div import fpva_pkg::*; #(
    parameter int WORD_BITS = FPVA_WORD_BITS,
    parameter int FRAC_BITS = FPVA_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [WORD_BITS-1:0]           i_num,
    input  logic [WORD_BITS:0]             i_den,
    output logic [WORD_BITS+FRAC_BITS-1:0] o_quo,
    output logic                           o_dz
);
    localparam int W  = WORD_BITS;
    localparam int NB = WORD_BITS + FRAC_BITS;
    localparam int RW = W + 2;

    logic [RW-1:0] r_rem [NB];
    logic [RW-1:0] p_rem [NB];
    logic [RW-1:0] n_rem [NB];
    logic [NB-1:0] r_num [NB];
    logic [NB-1:0] p_num [NB];
    logic [NB-1:0] r_quo [NB];
    logic [NB-1:0] p_quo [NB];
    logic [NB-1:0] n_quo [NB];
    logic [W:0]    r_den [NB];
    logic [W:0]    p_den [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign p_rem[k] = '0;
            assign p_num[k] = {i_num, {FRAC_BITS{1'b0}}};
            assign p_quo[k] = '0;
            assign p_den[k] = i_den;
        end else begin : g_next
            assign p_rem[k] = r_rem[k-1];
            assign p_num[k] = r_num[k-1];
            assign p_quo[k] = r_quo[k-1];
            assign p_den[k] = r_den[k-1];
        end

        always_comb begin
            logic [RW-1:0] rem2;
            rem2 = {p_rem[k][RW-2:0], p_num[k][NB-1]};
            if (rem2 >= RW'(p_den[k])) begin
                n_rem[k] = rem2 - RW'(p_den[k]);
                n_quo[k] = {p_quo[k][NB-2:0], 1'b1};
            end else begin
                n_rem[k] = rem2;
                n_quo[k] = {p_quo[k][NB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= {p_num[k][NB-2:0], 1'b0};
                r_quo[k] <= n_quo[k];
                r_den[k] <= p_den[k];
            end
        end
    end

    assign o_quo = r_quo[NB-1];
    assign o_dz  = (r_den[NB-1] == '0);
endmodule

// ----- sv/fixed_point_vector_alu.sv -----
// Top level of the fixed point vector ALU: input stage, four lanes, merge,
// square root and divider pipelines, result select. Depends on fpva_pkg and all fpva_* modules.
//
// Usage:
//   Input stream s_axis: tdata carries a_x..a_w, b_x..b_w, scalar_in; tuser the opcode.
//   Output stream m_axis: tdata carries r_x..r_w, scalar_out; tuser the status code.
//   cfg channel writes component_count (always ready); the user must write it only
//   while the block is idle, which the block itself does not enforce.
//   Every opcode runs through the same pipeline of 2*WORD_BITS + FRAC_BITS + 6
//   register stages; the square root stage has WORD_BITS+1 steps and the divider
//   WORD_BITS+FRAC_BITS steps, one bit per stage, with Q16.16 data by default.
//   Throughput is one word per cycle while the receiver does not stall.
//   The whole pipeline advances only when the output register is empty or taken, so a
//   stalled receiver freezes every stage and drops s_axis tready in the same cycle.
//   Synchronous active-low reset clears all valid bits and sets component_count to 4.
`timescale 1ns / 1ps
`include "fixed_point_vector_alu_defines.svh"
module fixed_point_vector_alu import fpva_pkg::*; #(
    parameter int FRAC_BITS = FPVA_FRAC_BITS,
    parameter int WORD_BITS = FPVA_WORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in
    input  logic [((9*WORD_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    // req_type
    input  logic [3:0]                            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // r_x, r_y, r_z, r_w, scalar_out
    output logic [((5*WORD_BITS+7)/8)*8-1:0]      o_m_axis_tdata,
    // status
    output logic [1:0]                            o_m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [2:0]                            i_cfg_data
);
    localparam int W        = WORD_BITS;
    localparam int F        = FRAC_BITS;
    localparam int OUT_BITS = ((5*W+7)/8)*8;
    localparam int SQ       = W + 1;
    localparam int NB       = W + F;
    localparam int M        = SQ + NB;
    localparam int LAT      = M + 5;
    localparam int PW       = 2*W + 2;
    localparam logic [NB-1:0] QLIM = NB'(1) << (W-1);

    typedef struct packed {
        t_op                          op;
        logic [2:0]                   n;
        logic [FPVA_LANES-1:0][W-1:0] a;
        logic [W-1:0]                 s;
    } t_front;

    typedef struct packed {
        t_op                          op;
        logic [2:0]                   n;
        logic [FPVA_LANES-1:0][W-1:0] a;
        logic [W-1:0]                 s;
        logic [FPVA_LANES-1:0][W-1:0] v;
        logic                         vovf;
        logic [W-1:0]                 scal;
        logic                         sovf;
    } t_meta;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? W'(0) - v : v;
    endfunction

    logic                           en;
    logic [2:0]                     r_cnt;
    logic [LAT-1:0]                 r_vld;
    t_front                         n_f1;
    logic [FPVA_LANES-1:0][W-1:0]   n_b1;
    t_front                         r_f1;
    t_front                         r_f2;
    t_front                         r_f3;
    t_front                         r_f4;
    logic [FPVA_LANES-1:0][W-1:0]   r_b1;
    logic [FPVA_LANES-1:0][PW-1:0]  lane_sum;
    logic [FPVA_LANES-1:0][W:0]     lane_e;
    logic [FPVA_LANES-1:0][W-1:0]   mg_v;
    logic                           mg_vovf;
    logic [W-1:0]                   mg_scal;
    logic                           mg_sovf;
    logic [2*W:0]                   mg_acc;
    logic [W:0]                     root;
    t_meta                          meta_in;
    t_meta                          r_meta [M];
    t_meta                          tap;
    t_meta                          fm;
    logic [W:0]                     den;
    logic [FPVA_LANES-1:0][NB-1:0]  quo;
    logic [FPVA_LANES-1:0]          dz_all;
    logic                           dz;
    logic [FPVA_LANES-1:0][W-1:0]   qs;
    logic [FPVA_LANES-1:0]          qovf;
    logic [FPVA_LANES-1:0][W-1:0]   fr;
    logic [W-1:0]                   fscal;
    logic                           fovf;
    t_status                        fst;
    logic                           qneg;
    logic [5*W-1:0]                 r_od;
    t_status                        r_ost;

    assign en              = ~r_vld[LAT-1] | i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_RESET;
        end else if (i_cfg_valid) begin
            r_cnt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    always_comb begin
        n_f1.op = t_op'(i_s_axis_tuser);
        if (r_cnt < CNT_MIN) begin
            n_f1.n = CNT_MIN;
        end else if (r_cnt > CNT_MAX) begin
            n_f1.n = CNT_MAX;
        end else begin
            n_f1.n = r_cnt;
        end
        for (int i = 0; i < FPVA_LANES; i++) begin
            n_f1.a[i] = i_s_axis_tdata[i*W +: W];
            n_b1[i]   = i_s_axis_tdata[(i+FPVA_LANES)*W +: W];
        end
        n_f1.s = i_s_axis_tdata[2*FPVA_LANES*W +: W];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1 <= n_f1;
            r_b1 <= n_b1;
            r_f2 <= r_f1;
            r_f3 <= r_f2;
            r_f4 <= r_f3;
        end
    end

    for (genvar i = 0; i < FPVA_LANES; i++) begin : g_lane
        fpva_lane #(
            .WORD_BITS (WORD_BITS),
            .LANE      (i)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_op  (r_f1.op),
            .i_n   (r_f1.n),
            .i_a   (r_f1.a),
            .i_b   (r_b1),
            .i_s   (r_f1.s),
            .o_sum (lane_sum[i]),
            .o_e   (lane_e[i])
        );
    end

    fpva_merge #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_op   (r_f3.op),
        .i_n    (r_f3.n),
        .i_a    (r_f3.a),
        .i_sum  (lane_sum),
        .i_e    (lane_e),
        .o_v    (mg_v),
        .o_vovf (mg_vovf),
        .o_scal (mg_scal),
        .o_sovf (mg_sovf),
        .o_acc  (mg_acc)
    );

    fpva_sqrt #(
        .WORD_BITS (WORD_BITS)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  ({1'b0, mg_acc}),
        .o_root (root)
    );

    always_comb begin
        meta_in.op   = r_f4.op;
        meta_in.n    = r_f4.n;
        meta_in.a    = r_f4.a;
        meta_in.s    = r_f4.s;
        meta_in.v    = mg_v;
        meta_in.vovf = mg_vovf;
        meta_in.scal = mg_scal;
        meta_in.sovf = mg_sovf;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= meta_in;
            for (int k = 1; k < M; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    assign tap = r_meta[SQ-1];
    assign den = (tap.op == OP_UNIT) ? root : {1'b0, mag(tap.s)};

    for (genvar i = 0; i < FPVA_LANES; i++) begin : g_div
        fpva_div #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (mag(tap.a[i])),
            .i_den (den),
            .o_quo (quo[i]),
            .o_dz  (dz_all[i])
        );
    end

    assign dz = |dz_all;
    assign fm = r_meta[M-1];

    always_comb begin
        qneg = 1'b0;
        for (int i = 0; i < FPVA_LANES; i++) begin
            qneg = fm.a[i][W-1] ^ ((fm.op == OP_DIVS) & fm.s[W-1]);
            if (qneg) begin
                qovf[i] = (quo[i] > QLIM);
                qs[i]   = qovf[i] ? {1'b1, {(W-1){1'b0}}} : W'(0) - quo[i][W-1:0];
            end else begin
                qovf[i] = (quo[i] >= QLIM);
                qs[i]   = qovf[i] ? {1'b0, {(W-1){1'b1}}} : quo[i][W-1:0];
            end
        end
    end

    always_comb begin
        fr    = fm.v;
        fscal = fm.scal;
        fovf  = fm.vovf | fm.sovf;
        fst   = ST_OK;
        if (fm.op == OP_DIVS || fm.op == OP_UNIT) begin
            fovf = 1'b0;
            if (dz) begin
                fst = (fm.op == OP_DIVS) ? ST_DIVZ : ST_ZLEN;
            end else begin
                for (int i = 0; i < FPVA_LANES; i++) begin
                    if (3'(i) < fm.n) begin
                        fr[i] = qs[i];
                        fovf  = fovf | qovf[i];
                    end
                end
            end
        end
        if (fst == ST_OK && fovf) begin
            fst = ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_od  <= {fscal, fr};
            r_ost <= fst;
        end
    end

    assign o_m_axis_tdata = OUT_BITS'(r_od);
    assign o_m_axis_tuser = r_ost;

    `ASSERT_IMPLY(a_divz_no_scalar, o_m_axis_tvalid && o_m_axis_tuser == ST_DIVZ, o_m_axis_tdata[4*W +: W] == '0)
    `ASSERT_IMPLY(a_zlen_no_scalar, o_m_axis_tvalid && o_m_axis_tuser == ST_ZLEN, o_m_axis_tdata[4*W +: W] == '0)
    `ASSERT_NEXT(a_stall_freezes_pipe, o_m_axis_tvalid && !i_m_axis_tready, r_vld == $past(r_vld))
endmodule

// ----- test/tb_top.sv -----
// Testbench for fixed_point_vector_alu: a directed table, then random words under
// random stalls, each result checked against its table entry or a bit-exact predictor of the ALU.
// Depends on fpva_pkg and the fixed_point_vector_alu RTL.
`timescale 1ns / 1ps
module tb_top import fpva_pkg::*; ();

    typedef logic signed [127:0] wide_t;
    typedef logic signed [31:0] word_t;

    typedef struct packed {
        word_t   r_x, r_y, r_z, r_w, scal;
        t_status st;
    } alu_result_t;

    typedef struct packed {
        logic [3:0]  op;
        word_t       a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, s;
        bit          typed;
        alu_result_t res;
    } table_row_t;

    localparam wide_t W_MAX = 128'sd2147483647;
    localparam wide_t W_MIN = -128'sd2147483648;
    localparam word_t MAXW = 32'sh7fffffff;
    localparam word_t MINW = 32'sh80000000;
    localparam logic [3:0] OP_LAST_UNUSED = 4'hf;
    localparam int IDLE_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [287:0] i_s_axis_tdata = '0;
    logic [3:0] i_s_axis_tuser = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [159:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_data = '0;

    alu_result_t result_q[$];
    logic [2:0] lane_count = CNT_RESET;
    int errors = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_req = 0;

    always #5 i_clk = ~i_clk;

    fixed_point_vector_alu u_top (.*);

    function automatic word_t sat_word(input wide_t v, inout bit ovf);
        if (v > W_MAX) begin
            ovf = 1;
            return MAXW;
        end
        if (v < W_MIN) begin
            ovf = 1;
            return MINW;
        end
        return word_t'(v);
    endfunction

    function automatic wide_t smul(input word_t a, input word_t b);
        wide_t ea, eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    function automatic word_t scale_sat(input wide_t p, inout bit ovf);
        return sat_word(p >>> FPVA_FRAC_BITS, ovf);
    endfunction

    function automatic word_t div_sat(input wide_t num, input wide_t den, inout bit ovf);
        logic [127:0] n, d, q;
        n = (num < 0 ? -num : num) << FPVA_FRAC_BITS;
        d = den < 0 ? -den : den;
        q = n / d;
        return sat_word(((num < 0) != (den < 0)) ? -wide_t'(q) : wide_t'(q), ovf);
    endfunction

    function automatic wide_t root_floor(input wide_t s);
        logic [127:0] root, c;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
            c = root | (128'd1 << b);
            if (c * c <= s) root = c;
        end
        return wide_t'(root);
    endfunction

    function automatic alu_result_t predict_alu(input logic [3:0] op, input logic [287:0] d,
                                                input logic [2:0] cnt);
        word_t a[4], b[4], r[4], s, scal;
        wide_t acc, root;
        bit ovf;
        t_status st;
        int n;
        for (int i = 0; i < 4; i++) begin
            a[i] = d[32*i +: 32];
            b[i] = d[128 + 32*i +: 32];
            r[i] = a[i];
        end
        s = d[256 +: 32];
        scal = 0;
        ovf = 0;
        st = ST_OK;
        acc = 0;
        n = cnt < CNT_MIN ? 2 : (cnt > CNT_MAX ? 4 : int'(cnt));
        case (op)
            OP_ADD:  for (int i = 0; i < n; i++) r[i] = sat_word(wide_t'(a[i]) + b[i], ovf);
            OP_SUB:  for (int i = 0; i < n; i++) r[i] = sat_word(wide_t'(a[i]) - b[i], ovf);
            OP_MUL:  for (int i = 0; i < n; i++) r[i] = scale_sat(smul(a[i], b[i]), ovf);
            OP_ADDS: for (int i = 0; i < n; i++) r[i] = sat_word(wide_t'(a[i]) + s, ovf);
            OP_MULS: for (int i = 0; i < n; i++) r[i] = scale_sat(smul(a[i], s), ovf);
            OP_DIVS: begin
                if (s == 0) st = ST_DIVZ;
                else for (int i = 0; i < n; i++) r[i] = div_sat(a[i], s, ovf);
            end
            OP_DOT, OP_LENSQ: begin
                for (int i = 0; i < n; i++) acc += smul(a[i], op == OP_DOT ? b[i] : a[i]);
                scal = scale_sat(acc, ovf);
            end
            OP_CROSS: begin
                r[0] = scale_sat(smul(a[1], b[2]) - smul(a[2], b[1]), ovf);
                r[1] = scale_sat(smul(a[2], b[0]) - smul(a[0], b[2]), ovf);
                r[2] = scale_sat(smul(a[0], b[1]) - smul(a[1], b[0]), ovf);
            end
            OP_QUAT: begin
                acc = smul(a[0], b[0]) + smul(a[1], b[1]) + smul(a[2], b[2]);
                r[3] = scale_sat(smul(a[3], b[3]) - acc, ovf);
                r[0] = scale_sat(smul(a[3], b[0]) + smul(b[3], a[0])
                                 + smul(a[1], b[2]) - smul(a[2], b[1]), ovf);
                r[1] = scale_sat(smul(a[3], b[1]) + smul(b[3], a[1])
                                 + smul(a[2], b[0]) - smul(a[0], b[2]), ovf);
                r[2] = scale_sat(smul(a[3], b[2]) + smul(b[3], a[2])
                                 + smul(a[0], b[1]) - smul(a[1], b[0]), ovf);
            end
            OP_UNIT: begin
                for (int i = 0; i < n; i++) acc += smul(a[i], a[i]);
                root = root_floor(acc);
                if (root == 0) st = ST_ZLEN;
                else for (int i = 0; i < n; i++) r[i] = div_sat(a[i], root, ovf);
            end
            default: ;
        endcase
        if (st == ST_OK && ovf) st = ST_SAT;
        return '{r[0], r[1], r[2], r[3], scal, st};
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
        errors++;
    endtask

    function automatic word_t rand_word();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) return word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        if (k == 4) return $urandom_range(0, 1) ? MAXW : MINW;
        if (k == 5) return 0;
        return word_t'($urandom);
    endfunction

    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 0;
        if (k < 96) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [3:0] op, input logic [287:0] d,
                             input bit typed, input alu_result_t res);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= d;
        i_s_axis_tuser <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        result_q.push_back(typed ? res : predict_alu(op, d, lane_count));
        gap = rand_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_write(input logic [2:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lane_count = v;
    endtask

    // receiver: random stalls, one long hold-off on request, checks
    always @(posedge i_clk) begin
        alu_result_t want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (result_q.size() == 0) begin
                $display("unexpected result word at %0t", $time);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (o_m_axis_tdata[31:0] !== want.r_x) report("r_x", o_m_axis_tdata[31:0], want.r_x);
                if (o_m_axis_tdata[63:32] !== want.r_y) report("r_y", o_m_axis_tdata[63:32], want.r_y);
                if (o_m_axis_tdata[95:64] !== want.r_z) report("r_z", o_m_axis_tdata[95:64], want.r_z);
                if (o_m_axis_tdata[127:96] !== want.r_w) report("r_w", o_m_axis_tdata[127:96], want.r_w);
                if (o_m_axis_tdata[159:128] !== want.scal)
                    report("scalar_out", o_m_axis_tdata[159:128], want.scal);
                if (o_m_axis_tuser !== want.st) report("status", o_m_axis_tuser, want.st);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 300;
            i_m_axis_tready <= 1'b0;
        end else if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= rand_gap() == 0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        table_row_t dir[$];
        logic [2:0] counts[$];
        logic [3:0] op;
        logic [287:0] d;
        dir = '{
            '{OP_ADD, MAXW, 1, 0, 0, 1, 1, 0, 0, 0, 1, '{MAXW, 2, 0, 0, 0, ST_SAT}},
            '{OP_SUB, MINW, 5, 0, 0, 1, 2, 0, 0, 0, 1, '{MINW, 3, 0, 0, 0, ST_SAT}},
            '{OP_DIVS, 1, 2, 3, 4, 0, 0, 0, 0, 0, 1, '{1, 2, 3, 4, 0, ST_DIVZ}},
            '{OP_UNIT, 0, 0, 0, 0, 7, 7, 7, 7, 7, 1, '{0, 0, 0, 0, 0, ST_ZLEN}},
            '{OP_UNIT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{32'sh10000, 0, 0, 0, 0, ST_OK}},
            '{OP_LAST_UNUSED, 5, 6, 7, 8, 1, 1, 1, 1, 1, 1, '{5, 6, 7, 8, 0, ST_OK}},
            '{OP_ADD, 1, -1, 2, -2, 3, 4, 5, 6, 0, 0, '0},
            '{OP_MUL, MAXW, MINW, 32'sh10000, -32'sh8000, MAXW, MINW, 3, 5, 0, 0, '0},
            '{OP_MUL, -1, 1, MINW, 0, 1, -1, MINW, 0, 0, 0, '0},
            '{OP_ADDS, MAXW, MINW, 0, 1, 0, 0, 0, 0, -1, 0, '0},
            '{OP_MULS, 32'sh18000, -3, MINW, MAXW, 0, 0, 0, 0, 32'sh20000, 0, '0},
            '{OP_DIVS, MAXW, MINW, 32'sh10000, -7, 0, 0, 0, 0, 1, 0, '0},
            '{OP_DIVS, MINW, 3, 32'sh30000, -1, 0, 0, 0, 0, -1, 0, '0},
            '{OP_DOT, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, 0, 0, '0},
            '{OP_DOT, 32'sh10000, 2, -3, 4, -5, 6, 7, 8, 0, 0, '0},
            '{OP_LENSQ, MINW, MINW, MINW, MINW, 0, 0, 0, 0, 0, 0, '0},
            '{OP_LENSQ, 32'sh100, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0},
            '{OP_CROSS, 32'sh10000, 0, 0, 9, 0, 32'sh10000, 0, 0, 0, 0, '0},
            '{OP_CROSS, MAXW, MINW, MAXW, 1, MINW, MAXW, MINW, 2, 0, 0, '0},
            '{OP_QUAT, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh40000,
              5, -32'sh10000, 32'sh8000, 32'sh10000, 0, 0, '0},
            '{OP_QUAT, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MAXW, 0, 0, '0},
            '{OP_UNIT, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0, 0, 0, 0, '0},
            '{OP_UNIT, MINW, MAXW, MINW, MAXW, 0, 0, 0, 0, 0, 0, '0},
            '{OP_UNIT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0},
            '{OP_LAST_UNUSED - 4'd3, 1, 2, 3, 4, 5, 6, 7, 8, 9, 0, '0}
        };
        counts = '{CNT_MIN, 3'd3, CNT_MAX, 3'd0, 3'd1, 3'd5, 3'd6, 3'd7, CNT_MAX};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir[k]) begin
            send_word(dir[k].op, {dir[k].s, dir[k].b_w, dir[k].b_z, dir[k].b_y, dir[k].b_x,
                      dir[k].a_w, dir[k].a_z, dir[k].a_y, dir[k].a_x}, dir[k].typed, dir[k].res);
        end
        foreach (counts[c]) begin
            drain_and_write(counts[c]);
            for (int k = 0; k < 80; k++) begin
                if (c == 2 && k == 10) hold_req = 1;
                op = $urandom_range(0, 19) < 18 ? 4'($urandom_range(0, 10))
                                                : 4'($urandom_range(0, 15));
                for (int f = 0; f < 9; f++) d[32*f +: 32] = rand_word();
                send_word(op, d, 0, '0);
            end
        end
        i_s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
